/* design/rcfr_pkg.sv */
// Package for the region cache: opcodes, status codes, entry and scan types.
// No dependencies.
`default_nettype none
package rcfr_pkg;
  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_EVICT  = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_MISS  = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_COMMIT, S_OUT} state_e;

  typedef struct packed {
    logic [15:0] file_id;
    logic [15:0] sx;
    logic [15:0] sy;
    logic [15:0] ex;
    logic [15:0] ey;
    logic [15:0] uses;
    logic [31:0] last;
    logic [31:0] bytes;
    logic [31:0] order;
  } entry_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] file_id;
    logic [15:0] sx;
    logic [15:0] sy;
    logic [15:0] ex;
    logic [15:0] ey;
    logic [31:0] now;
  } req_t;

  // Best-candidate record type: a found flag and an entry
  typedef struct packed {
    logic        found;
    entry_t      ent;
  } cand_t;
endpackage
`default_nettype wire

/* design/rcfr_if.sv */
// Valid/ready channel interfaces for request and result words.
// Depends on nothing.
`default_nettype none
interface rcfr_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] file_id;
  logic [15:0] start_x;
  logic [15:0] start_y;
  logic [15:0] end_x;
  logic [15:0] end_y;
  logic [31:0] now;
  logic [15:0] initial_count;
  logic [31:0] region_size;
  modport source (output valid, opcode, file_id, start_x, start_y, end_x, end_y, now,
                  initial_count, region_size, input ready);
  modport sink (input valid, opcode, file_id, start_x, start_y, end_x, end_y, now,
                initial_count, region_size, output ready);
endinterface

interface rcfr_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  slot;
  logic [15:0] hit_file_id;
  logic [15:0] hit_start_x;
  logic [15:0] hit_start_y;
  logic [15:0] hit_end_x;
  logic [15:0] hit_end_y;
  logic [15:0] hit_count;
  modport source (output valid, status, slot, hit_file_id, hit_start_x, hit_start_y,
                  hit_end_x, hit_end_y, hit_count, input ready);
  modport sink (input valid, status, slot, hit_file_id, hit_start_x, hit_start_y,
                hit_end_x, hit_end_y, hit_count, output ready);
endinterface
`default_nettype wire

/* design/rcfr_cell.sv */
// One table slot of the ring: holds an entry and rotates it to its neighbour.
// Depends on rcfr_pkg.
`default_nettype none
module rcfr_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            shift_i,
  input  wire logic            valid_i,
  input  wire rcfr_pkg::entry_t ent_i,
  input  wire logic [7:0]      idx_i,
  output logic                 valid_o,
  output rcfr_pkg::entry_t     ent_o,
  output logic [7:0]           idx_o
);
  import rcfr_pkg::*;
  logic valid_q;
  entry_t ent_q;
  logic [7:0] idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      ent_q <= ent_i;
      idx_q <= idx_i;
    end
  end

  assign valid_o = valid_q;
  assign ent_o   = ent_q;
  assign idx_o   = idx_q;
endmodule
`default_nettype wire

/* design/region_cache_frequency_recency_policy_top.sv */
// Region cache with frequency-over-age replacement.
// The result shows once the scan and commit rotations are done; one word at a time:
// a new word is accepted only after the result has been taken.
// The slots form a ring of cells that rotates twice per operation: once past a single
// compare unit (one 16x33 multiply pair per step), once to apply the edit.
// Reset clears all valid bits and the stamp counter; the slot tags load while reset is
// held, so the clock runs during reset; entry payloads are not reset.
`default_nettype none
module region_cache_frequency_recency_policy_top #(
  parameter int ENTRIES = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rcfr_req_if.sink  req,
  rcfr_rsp_if.source rsp
);
  import rcfr_pkg::*;
  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  state_e state_q, state_d;
  req_t   rq_q;
  logic [15:0] cnt_q;
  logic [31:0] size_q;
  logic [31:0] order_q;
  logic [CW-1:0] step_q;

  logic shift;
  logic   cv_i [ENTRIES];
  entry_t ce_i [ENTRIES];
  logic [7:0] cx_i [ENTRIES];
  logic   cv_o [ENTRIES];
  entry_t ce_o [ENTRIES];
  logic [7:0] cx_o [ENTRIES];

  // best candidate
  logic        bf_q;
  entry_t      be_q;
  logic [IW-1:0] bi_q;
  logic        bfree_q;
  logic [IW-1:0] fi_q;

  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      rcfr_cell u_cell (
        .clk_i, .rst_ni, .shift_i(shift),
        .valid_i(cv_i[g]), .ent_i(ce_i[g]), .idx_i(cx_i[g]),
        .valid_o(cv_o[g]), .ent_o(ce_o[g]), .idx_o(cx_o[g])
      );
    end
  endgenerate

  // the head cell (index 0) is examined each step; ring rotates toward 0
  entry_t head;
  logic   head_v;
  logic [IW-1:0] head_i;
  assign head   = ce_o[0];
  assign head_v = cv_o[0];
  assign head_i = cx_o[0][IW-1:0];

  logic [31:0] age_h, age_b;
  logic [48:0] lhs, rhs;
  logic hit_ok, better;
  always_comb begin
    age_h = (rq_q.now >= head.last) ? rq_q.now - head.last : 32'd0;
    age_b = (rq_q.now >= be_q.last) ? rq_q.now - be_q.last : 32'd0;
    lhs = 49'(head.uses) * (49'(age_b) + 49'd1);
    rhs = 49'(be_q.uses) * (49'(age_h) + 49'd1);
    hit_ok = head_v && head.file_id == rq_q.file_id && head.sx <= rq_q.sx &&
             head.sy <= rq_q.sy && head.ex >= rq_q.ex && head.ey >= rq_q.ey;
    better = 1'b0;
    case (rq_q.op)
      OP_LOOKUP: better = hit_ok && (!bf_q || head.order < be_q.order ||
                          (head.order == be_q.order && head_i < bi_q));
      OP_EVICT:  better = head_v && (!bf_q || lhs < rhs ||
                          (lhs == rhs && head.bytes > be_q.bytes) ||
                          (lhs == rhs && head.bytes == be_q.bytes && head_i < bi_q));
      default:   better = 1'b0;
    endcase
  end

  // commit edit applied to the chosen slot while it passes the head on rotation
  logic editing;
  assign editing = (state_q == S_COMMIT);

  // touched count, held at the maximum
  logic [15:0] bump_uses;
  assign bump_uses = (be_q.uses != 16'hFFFF) ? be_q.uses + 16'd1 : be_q.uses;

  always_comb begin
    for (int k = 0; k < ENTRIES; k++) begin
      cv_i[k] = cv_o[(k + 1) % ENTRIES];
      ce_i[k] = ce_o[(k + 1) % ENTRIES];
      cx_i[k] = cx_o[(k + 1) % ENTRIES];
    end
    if (editing && bf_q && head_i == bi_q) begin
      case (rq_q.op)
        OP_LOOKUP: begin
          ce_i[ENTRIES-1].uses  = bump_uses;
          ce_i[ENTRIES-1].last  = rq_q.now;
          ce_i[ENTRIES-1].order = order_q;
        end
        OP_EVICT: cv_i[ENTRIES-1] = 1'b0;
        default: ;
      endcase
    end
    if (editing && rq_q.op == OP_INSERT && bfree_q && head_i == fi_q) begin
      cv_i[ENTRIES-1] = 1'b1;
      ce_i[ENTRIES-1] = '{file_id: rq_q.file_id, sx: rq_q.sx, sy: rq_q.sy, ex: rq_q.ex,
                          ey: rq_q.ey, uses: cnt_q, last: rq_q.now, bytes: size_q,
                          order: order_q};
    end
    if (!rst_ni) begin
      for (int k = 0; k < ENTRIES; k++) cx_i[k] = 8'(k);
    end
  end

  // the ring spins during scan and commit; after reset the index tags load once
  logic init_q;
  assign shift = (state_q == S_SCAN) || (state_q == S_COMMIT) || !init_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (req.valid) state_d = S_SCAN;
      S_SCAN:   if (step_q == CW'(ENTRIES - 1)) state_d = S_COMMIT;
      S_COMMIT: if (step_q == CW'(ENTRIES - 1)) state_d = S_OUT;
      S_OUT:    if (rsp.ready) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  assign req.ready = (state_q == S_IDLE) && init_q;

  logic [1:0] st_q, st_d;
  entry_t oe_q, oe_d;
  logic [IW-1:0] os_q, os_d;

  always_comb begin
    st_d = ST_MISS;
    oe_d = '0;
    os_d = '0;
    case (rq_q.op)
      OP_LOOKUP: if (bf_q) begin
          st_d = ST_DONE;
          oe_d = be_q;
          oe_d.uses = bump_uses;
          os_d = bi_q;
        end
      OP_INSERT: if (bfree_q) begin
          st_d = ST_DONE;
          os_d = fi_q;
          oe_d = '{file_id: rq_q.file_id, sx: rq_q.sx, sy: rq_q.sy, ex: rq_q.ex,
                   ey: rq_q.ey, uses: cnt_q, last: '0, bytes: '0, order: '0};
        end else st_d = ST_FULL;
      OP_EVICT: if (bf_q) begin
          st_d = ST_DONE;
          oe_d = be_q;
          os_d = bi_q;
        end else st_d = ST_EMPTY;
      default: st_d = ST_MISS;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      order_q <= '0;
      step_q  <= '0;
      init_q  <= 1'b0;
    end else begin
      init_q <= 1'b1;
      if (state_q == S_IDLE && !init_q) state_q <= S_IDLE;
      else state_q <= state_d;
      if (state_q == S_SCAN || state_q == S_COMMIT)
        step_q <= (step_q == CW'(ENTRIES - 1)) ? '0 : step_q + 1'b1;
      // advance the stamp once the edit has written the current one
      if (state_q == S_COMMIT && step_q == CW'(ENTRIES - 1) &&
          ((rq_q.op == OP_LOOKUP && bf_q) || (rq_q.op == OP_INSERT && bfree_q)))
        order_q <= order_q + 32'd1;
    end
  end

  // capture the word, track the best candidate, hold the result
  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) begin
      rq_q   <= '{op: req.opcode, file_id: req.file_id, sx: req.start_x, sy: req.start_y,
                  ex: req.end_x, ey: req.end_y, now: req.now};
      cnt_q  <= req.initial_count;
      size_q <= req.region_size;
      bf_q   <= 1'b0;
      bfree_q <= 1'b0;
    end else if (state_q == S_SCAN) begin
      if (better) begin
        bf_q <= 1'b1;
        be_q <= head;
        bi_q <= head_i;
      end
      if (!head_v && (!bfree_q || head_i < fi_q)) begin
        bfree_q <= 1'b1;
        fi_q    <= head_i;
      end
    end
    if (state_q == S_COMMIT && step_q == CW'(ENTRIES - 1)) begin
      st_q <= st_d;
      oe_q <= oe_d;
      os_q <= os_d;
    end
  end

  assign rsp.valid       = (state_q == S_OUT);
  assign rsp.status      = st_q;
  assign rsp.slot        = 4'(os_q);
  assign rsp.hit_file_id = oe_q.file_id;
  assign rsp.hit_start_x = oe_q.sx;
  assign rsp.hit_start_y = oe_q.sy;
  assign rsp.hit_end_x   = oe_q.ex;
  assign rsp.hit_end_y   = oe_q.ey;
  assign rsp.hit_count   = oe_q.uses;
endmodule
`default_nettype wire

/* design/rcfr_checker.sv */
// Port-level checker for the region cache, bound to the top level.
// Depends on rcfr_pkg and the interfaces.
`default_nettype none
module rcfr_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_i,
  input wire logic out_valid_i,
  input wire logic out_ready_i,
  input wire logic [1:0] status_i,
  input wire logic [15:0] hit_count_i
);
  import rcfr_pkg::*;
  // one word in flight: no new word while a result is shown
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i) else $error("accept while result pending");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i))
    else $error("result dropped");
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != ST_DONE |-> hit_count_i == 16'd0)
    else $error("miss carries data");
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !out_valid_i) else $error("result too early");
endmodule

bind region_cache_frequency_recency_policy_top rcfr_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i(req.valid), .in_ready_i(req.ready),
  .out_valid_i(rsp.valid), .out_ready_i(rsp.ready), .status_i(rsp.status),
  .hit_count_i(rsp.hit_count)
);
`default_nettype wire
